// File: rtl/core/imu_quaternion_frame_parser_assert.svh
// assertion macros for the imu quaternion frame parser checker
`ifndef IMU_QUATERNION_FRAME_PARSER_ASSERT_SVH
`define IMU_QUATERNION_FRAME_PARSER_ASSERT_SVH

// checked only outside reset
`define IQFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define IQFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/iqfp_pkg.sv
package iqfp_pkg;

  localparam int PAYLOAD_BYTES = 8;
  localparam int PAY_CNT_W = $clog2(PAYLOAD_BYTES);
  localparam logic [PAY_CNT_W-1:0] LAST_PAY = PAY_CNT_W'(PAYLOAD_BYTES - 1);

  localparam logic [7:0] SYNC_RESET = 8'h55;
  localparam logic [7:0] TYPE_RESET = 8'h59;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TYPE = 2'd1;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_TYPE,
    ST_PAYLOAD,
    ST_CKSUM
  } state_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_word_t;

  typedef struct packed {
    logic signed [15:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
    logic signed [15:0] q_largest;
    logic               checksum_good;
    logic [31:0]        frames_seen;
    logic [31:0]        frames_bad;
  } result_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [7:0]             reg_data;
  } cfg_word_t;

endpackage

// File: rtl/core/iqfp_stream_if.sv
interface iqfp_stream_if #(
  parameter type data_t = logic [7:0]
) ();

  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// File: rtl/core/imu_quaternion_frame_parser.sv
// Parses an IMU byte stream into quaternion frames: sync byte, type byte, eight
// little-endian payload bytes (w, x, y, z, signed Q1.15) and an 8-bit sum checksum
// over the first ten bytes. One byte is taken per clock; the result of a frame
// shows on the result channel the cycle after its checksum byte and sits in a
// single output register until taken. Only a checksum byte has to wait for that
// register, so rx.ready drops solely while a frame is ending and the previous
// result is still untaken. Quaternion fields and q_largest hold the last frame
// with a good checksum; frames_seen and frames_bad are saturating counters of
// COUNT_WIDTH bits shown as their low 32 bits. Write cfg index 0 (sync) or 1
// (type) only while the parser is idle; other indexes are ignored.
module imu_quaternion_frame_parser #(
  parameter int COUNT_WIDTH = 32
) (
  input logic           clk,
  input logic           rst,
  iqfp_stream_if.sink   rx,
  iqfp_stream_if.source result,
  iqfp_stream_if.sink   cfg
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  iqfp_pkg::state_t                        state, state_next;
  logic [iqfp_pkg::PAY_CNT_W-1:0]          pay_cnt, pay_cnt_next;
  logic [63:0]                             payload, payload_next;
  logic [7:0]                              run_sum, run_sum_next;
  logic [7:0]                              sync_byte, type_byte;
  logic signed [15:0]                      good_w, good_x, good_y, good_z, good_max;
  logic [COUNT_WIDTH-1:0]                  seen_count, bad_count;
  iqfp_pkg::result_t                       res, res_next;
  logic                                    res_valid;

  logic                                    rx_fire;
  logic                                    frame_done;
  logic                                    sum_ok;
  logic [7:0]                              b;
  logic signed [15:0]                      cand_w, cand_x, cand_y, cand_z;
  logic signed [15:0]                      max_01, max_23, cand_max;
  logic [COUNT_WIDTH-1:0]                  seen_inc, bad_inc;

  assign b        = rx.data.rx_byte;
  assign rx.ready = !(state == iqfp_pkg::ST_CKSUM && res_valid && !result.ready);
  assign rx_fire  = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;

  // payload is little endian, w in the low word
  assign cand_w   = payload[15:0];
  assign cand_x   = payload[31:16];
  assign cand_y   = payload[47:32];
  assign cand_z   = payload[63:48];
  assign max_01   = (cand_x > cand_w) ? cand_x : cand_w;
  assign max_23   = (cand_z > cand_y) ? cand_z : cand_y;
  assign cand_max = (max_23 > max_01) ? max_23 : max_01;

  assign sum_ok   = (b == run_sum);
  assign seen_inc = (seen_count == COUNT_MAX) ? seen_count : seen_count + 1'b1;
  assign bad_inc  = (bad_count == COUNT_MAX) ? bad_count : bad_count + 1'b1;

  always_comb begin
    state_next   = state;
    pay_cnt_next = pay_cnt;
    payload_next = payload;
    run_sum_next = run_sum;
    frame_done   = 1'b0;
    if (rx_fire) begin
      unique case (state)
        iqfp_pkg::ST_HUNT: begin
          if (b == sync_byte) begin
            run_sum_next = b;
            state_next   = iqfp_pkg::ST_TYPE;
          end
        end
        iqfp_pkg::ST_TYPE: begin
          if (b == type_byte) begin
            run_sum_next = run_sum + b;
            pay_cnt_next = '0;
            state_next   = iqfp_pkg::ST_PAYLOAD;
          end else if (b == sync_byte) begin
            run_sum_next = b;
          end else begin
            state_next = iqfp_pkg::ST_HUNT;
          end
        end
        iqfp_pkg::ST_PAYLOAD: begin
          run_sum_next = run_sum + b;
          payload_next = {b, payload[63:8]};
          pay_cnt_next = pay_cnt + 1'b1;
          if (pay_cnt == iqfp_pkg::LAST_PAY) begin
            state_next = iqfp_pkg::ST_CKSUM;
          end
        end
        iqfp_pkg::ST_CKSUM: begin
          frame_done = 1'b1;
          state_next = iqfp_pkg::ST_HUNT;
        end
        default: begin
          state_next = iqfp_pkg::ST_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    res_next.checksum_good = sum_ok;
    res_next.frames_seen   = 32'(seen_inc);
    res_next.frames_bad    = sum_ok ? 32'(bad_count) : 32'(bad_inc);
    if (sum_ok) begin
      res_next.q_w       = cand_w;
      res_next.q_x       = cand_x;
      res_next.q_y       = cand_y;
      res_next.q_z       = cand_z;
      res_next.q_largest = cand_max;
    end else begin
      res_next.q_w       = good_w;
      res_next.q_x       = good_x;
      res_next.q_y       = good_y;
      res_next.q_z       = good_z;
      res_next.q_largest = good_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iqfp_pkg::ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    pay_cnt <= pay_cnt_next;
    payload <= payload_next;
    run_sum <= run_sum_next;
    if (frame_done) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte  <= iqfp_pkg::SYNC_RESET;
      type_byte  <= iqfp_pkg::TYPE_RESET;
      good_w     <= '0;
      good_x     <= '0;
      good_y     <= '0;
      good_z     <= '0;
      good_max   <= '0;
      seen_count <= '0;
      bad_count  <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.data.reg_index)
          iqfp_pkg::CFG_SYNC: sync_byte <= cfg.data.reg_data;
          iqfp_pkg::CFG_TYPE: type_byte <= cfg.data.reg_data;
          default: ;
        endcase
      end
      if (frame_done) begin
        seen_count <= seen_inc;
        if (sum_ok) begin
          good_w   <= cand_w;
          good_x   <= cand_x;
          good_y   <= cand_y;
          good_z   <= cand_z;
          good_max <= cand_max;
        end else begin
          bad_count <= bad_inc;
        end
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res;

endmodule

// File: rtl/core/iqfp_checker.sv
`include "imu_quaternion_frame_parser_assert.svh"

module iqfp_checker (
  input logic              clk,
  input logic              rst,
  input logic              rx_ready,
  input logic              res_valid,
  input logic              res_ready,
  input iqfp_pkg::result_t res_data
);

  // no result word right after reset
  `IQFP_ASSERT_ALWAYS(a_reset_clears_result, rst |=> !res_valid, "result valid after reset")

  // a stalled result word holds
  `IQFP_ASSERT(a_result_hold, res_valid && !res_ready |=> res_valid && $stable(res_data), "result changed while stalled")

  // input only backs up behind a stalled result
  `IQFP_ASSERT(a_rx_stall_cause, !rx_ready |-> res_valid && !res_ready, "rx stalled without output stall")

  // largest is one of the components and not below any of them
  `IQFP_ASSERT(a_largest_ok, res_valid |-> (res_data.q_largest == res_data.q_w || res_data.q_largest == res_data.q_x || res_data.q_largest == res_data.q_y || res_data.q_largest == res_data.q_z) && res_data.q_largest >= res_data.q_w && res_data.q_largest >= res_data.q_x && res_data.q_largest >= res_data.q_y && res_data.q_largest >= res_data.q_z, "q_largest inconsistent")

endmodule

bind imu_quaternion_frame_parser iqfp_checker u_iqfp_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_ready  (rx.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);
